>>> rtl/assert_macros.svh
// Assertion macros used by the checker of the shortest-path core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, switched off while reset is held.
`define AP_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, checked during reset as well.
`define AP_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/apsp_pkg.sv
// Shared widths, codes and controller/datapath structs of the shortest-path core.
`default_nettype none

package apsp_pkg;

	// Field widths of the item and result words.
	localparam int KIND_W     = 2;
	localparam int VTX_W      = 6;
	localparam int WEIGHT_W   = 16;
	localparam int DIST_OUT_W = 23;
	localparam int PRED_W     = 6;
	localparam int VC_W       = 7;
	localparam int DIST_W     = 24;

	// Distance table codes: all ones means no path; finite values saturate below it.
	localparam logic [DIST_W-1:0] DIST_INF = 24'hFF_FFFF;
	localparam logic [DIST_W-1:0] DIST_MAX = 24'h7F_FFFF;

	localparam logic [VC_W-1:0] VC_RESET = 7'd64;

	// Default sizes handed to the top level.
	localparam int MAX_VERTICES_DEF = 64;
	localparam int WEIGHT_BITS_DEF  = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR = 2'd0,
		KIND_EDGE  = 2'd1,
		KIND_SOLVE = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic clr_step;
		logic edge_rd;
		logic wr_ab;
		logic wr_ba;
		logic query_rd;
		logic load_result;
		logic k_clr;
		logic k_inc;
		logic i_clr;
		logic i_inc;
		logic j_clr;
		logic j_inc;
		logic ik_rd;
		logic ik_cap;
		logic kj_rd;
		logic relax;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		kind_t kind;
		logic  in_range;
		logic  n_zero;
		logic  ab_inf;
		logic  ba_inf;
		logic  self_loop;
		logic  ik_inf;
		logic  clr_last;
		logic  j_last;
		logic  i_last;
		logic  k_last;
	} ctl_sts_t;

endpackage

`default_nettype wire

>>> rtl/apsp_item_if.sv
// Valid/ready channel that carries one input word of the shortest-path core.
`default_nettype none

interface apsp_item_if import apsp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [VTX_W-1:0]    first_vertex;
	logic [VTX_W-1:0]    second_vertex;
	logic [WEIGHT_W-1:0] weight;

	modport source (
		output valid, kind, first_vertex, second_vertex, weight,
		input  ready
	);

	modport sink (
		input  valid, kind, first_vertex, second_vertex, weight,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/apsp_result_if.sv
// Valid/ready channel that carries one result word of the shortest-path core.
`default_nettype none

interface apsp_result_if import apsp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  reachable;
	logic [DIST_OUT_W-1:0] distance;
	logic [PRED_W-1:0]     predecessor;

	modport source (
		output valid, reachable, distance, predecessor,
		input  ready
	);

	modport sink (
		input  valid, reachable, distance, predecessor,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/apsp_ctrl.sv
// Controller state machine that sequences clears, edge loads, the relaxation loop and queries.
`default_nettype none

module apsp_ctrl import apsp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire ctl_sts_t sts,
	output ctl_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_CLEAR,
		ST_EDGE_AB,
		ST_EDGE_BA,
		ST_IK_RD,
		ST_IK_CHK,
		ST_KJ_RD,
		ST_RELAX,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands. Leaving a row steps i, then k, then finishes.
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.kind)
					KIND_CLEAR: begin
						state_nxt = ST_CLEAR;
					end
					KIND_EDGE: begin
						if (sts.in_range) begin
							cmd.edge_rd = 1'b1;
							state_nxt   = ST_EDGE_AB;
						end else begin
							state_nxt = ST_DONE;
						end
					end
					KIND_SOLVE: begin
						if (sts.n_zero) begin
							state_nxt = ST_DONE;
						end else begin
							cmd.k_clr = 1'b1;
							cmd.i_clr = 1'b1;
							state_nxt = ST_IK_RD;
						end
					end
					KIND_QUERY: begin
						cmd.query_rd = 1'b1;
						state_nxt    = ST_DONE;
					end
				endcase
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_EDGE_AB: begin
				cmd.wr_ab = sts.ab_inf;
				state_nxt = ST_EDGE_BA;
			end
			ST_EDGE_BA: begin
				// A self loop has a single diagonal entry, already handled.
				cmd.wr_ba = sts.ba_inf && !sts.self_loop;
				state_nxt = ST_DONE;
			end
			ST_IK_RD: begin
				cmd.ik_rd = 1'b1;
				state_nxt = ST_IK_CHK;
			end
			ST_IK_CHK: begin
				if (sts.ik_inf) begin
					if (!sts.i_last) begin
						cmd.i_inc = 1'b1;
						state_nxt = ST_IK_RD;
					end else if (!sts.k_last) begin
						cmd.k_inc = 1'b1;
						cmd.i_clr = 1'b1;
						state_nxt = ST_IK_RD;
					end else begin
						state_nxt = ST_DONE;
					end
				end else begin
					cmd.ik_cap = 1'b1;
					cmd.j_clr  = 1'b1;
					state_nxt  = ST_KJ_RD;
				end
			end
			ST_KJ_RD: begin
				cmd.kj_rd = 1'b1;
				state_nxt = ST_RELAX;
			end
			ST_RELAX: begin
				cmd.relax = 1'b1;
				if (!sts.j_last) begin
					cmd.j_inc = 1'b1;
					state_nxt = ST_KJ_RD;
				end else if (!sts.i_last) begin
					cmd.i_inc = 1'b1;
					state_nxt = ST_IK_RD;
				end else if (!sts.k_last) begin
					cmd.k_inc = 1'b1;
					cmd.i_clr = 1'b1;
					state_nxt = ST_IK_RD;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				// The result register is loaded once the previous word has left.
				if (!out_valid_q || out_ready) begin
					cmd.load_result = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_INIT;
			end
		endcase
	end

	// State and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/apsp_datapath.sv
// Datapath: distance and predecessor memories, loop counters, relaxation adder and result register.
`default_nettype none

module apsp_datapath import apsp_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [VC_W-1:0]       cfg_wdata,
	input  wire logic [KIND_W-1:0]     kind,
	input  wire logic [VTX_W-1:0]      first_vertex,
	input  wire logic [VTX_W-1:0]      second_vertex,
	input  wire logic [WEIGHT_W-1:0]   weight,
	input  wire ctl_cmd_t              cmd,
	output ctl_sts_t                   sts,
	output logic                       reachable,
	output logic [DIST_OUT_W-1:0]      distance,
	output logic [PRED_W-1:0]          predecessor
);

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int CMPW  = (CW > VC_W) ? CW : VC_W;
	localparam int XW    = VW + VTX_W;

	// Vertex number to table index; in-range vertices always fit.
	function automatic logic [VW-1:0] to_idx(input logic [VTX_W-1:0] v);
		logic [XW-1:0] x;
		x = XW'(v);
		return x[VW-1:0];
	endfunction

	logic [VC_W-1:0]     vertex_count_q;
	kind_t               kind_q;
	logic [VTX_W-1:0]    a_q;
	logic [VTX_W-1:0]    b_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [WEIGHT_W-1:0] w_masked;
	logic [VW-1:0]       a_idx;
	logic [VW-1:0]       b_idx;
	logic [VW-1:0]       k_q;
	logic [VW-1:0]       i_q;
	logic [VW-1:0]       j_q;
	logic [AW-1:0]       clr_q;
	logic [CMPW-1:0]     vc_ext;
	logic [CMPW-1:0]     max_ext;
	logic [CMPW-1:0]     n_ext;
	logic [CMPW-1:0]     n_last;
	logic                in_range;

	logic [DIST_W-1:0]   dist_mem [DEPTH];
	logic [PRED_W-1:0]   pred_mem [DEPTH];
	logic [AW-1:0]       rd_a_addr;
	logic [AW-1:0]       rd_b_addr;
	logic [AW-1:0]       rd_p_addr;
	logic                rd_en;
	logic [DIST_W-1:0]   rd_a_q;
	logic [DIST_W-1:0]   rd_b_q;
	logic [PRED_W-1:0]   rd_p_q;
	logic [DIST_W-1:0]   dik_q;
	logic [DIST_W-1:0]   sum;
	logic [DIST_W-1:0]   sum_sat;
	logic                better;
	logic                wr_en;
	logic                pwr_en;
	logic [AW-1:0]       wr_addr;
	logic [DIST_W-1:0]   wr_data;
	logic [PRED_W-1:0]   pwr_data;
	logic                res_reach_q;
	logic [DIST_OUT_W-1:0] res_dist_q;
	logic [PRED_W-1:0]   res_pred_q;
	logic                hit;

	// Vertex count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VC_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// Effective vertex count, limited by the table size.
	always_comb begin
		vc_ext  = CMPW'(vertex_count_q);
		max_ext = CMPW'(MAX_VERTICES);
		n_ext   = (vc_ext < max_ext) ? vc_ext : max_ext;
		n_last  = n_ext - CMPW'(1);
	end

	// Only the low weight bits that the build keeps take part.
	always_comb begin
		for (int b = 0; b < WEIGHT_W; b++) begin
			w_masked[b] = weight[b] & (b < WEIGHT_BITS);
		end
	end

	// Item word, held for the whole operation.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind_t'(kind);
			a_q    <= first_vertex;
			b_q    <= second_vertex;
			w_q    <= w_masked;
		end
	end

	assign a_idx    = to_idx(a_q);
	assign b_idx    = to_idx(b_q);
	assign in_range = (CMPW'(a_q) < n_ext) && (CMPW'(b_q) < n_ext);

	// Loop counters and the clearing sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			i_q   <= '0;
			j_q   <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + VW'(1);
			end
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + VW'(1);
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + VW'(1);
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Read address selection for the two distance ports and the predecessor port.
	always_comb begin
		rd_a_addr = {k_q, j_q};
		rd_b_addr = {i_q, j_q};
		rd_p_addr = {k_q, j_q};
		if (cmd.edge_rd) begin
			rd_a_addr = {a_idx, b_idx};
			rd_b_addr = {b_idx, a_idx};
		end else if (cmd.query_rd) begin
			rd_a_addr = {a_idx, b_idx};
			rd_p_addr = {a_idx, b_idx};
		end else if (cmd.ik_rd) begin
			rd_a_addr = {i_q, k_q};
		end
		rd_en = cmd.edge_rd || cmd.query_rd || cmd.ik_rd || cmd.kj_rd;
	end

	// Registered memory reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= dist_mem[rd_a_addr];
			rd_b_q <= dist_mem[rd_b_addr];
			rd_p_q <= pred_mem[rd_p_addr];
		end
		if (cmd.ik_cap) begin
			dik_q <= rd_a_q;
		end
	end

	// Relaxation: d(i,k) + d(k,j), saturated, against d(i,j).
	always_comb begin
		sum     = dik_q + rd_a_q;
		sum_sat = (sum > DIST_MAX) ? DIST_MAX : sum;
		better  = (rd_a_q != DIST_INF) && (sum_sat < rd_b_q);
	end

	// Write port selection.
	always_comb begin
		wr_en    = 1'b0;
		pwr_en   = 1'b0;
		wr_addr  = clr_q;
		wr_data  = DIST_INF;
		pwr_data = rd_p_q;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.wr_ab) begin
			wr_en    = 1'b1;
			pwr_en   = 1'b1;
			wr_addr  = {a_idx, b_idx};
			wr_data  = DIST_W'(w_q);
			pwr_data = a_q;
		end else if (cmd.wr_ba) begin
			wr_en    = 1'b1;
			pwr_en   = 1'b1;
			wr_addr  = {b_idx, a_idx};
			wr_data  = DIST_W'(w_q);
			pwr_data = b_q;
		end else if (cmd.relax && better) begin
			wr_en   = 1'b1;
			pwr_en  = 1'b1;
			wr_addr = {i_q, j_q};
			wr_data = sum_sat;
		end
	end

	// Memory writes.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			dist_mem[wr_addr] <= wr_data;
		end
		if (pwr_en) begin
			pred_mem[wr_addr] <= pwr_data;
		end
	end

	// Result word: only an in-range query of a finite pair reports anything.
	assign hit = (kind_q == KIND_QUERY) && in_range && (rd_a_q != DIST_INF);

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_reach_q <= hit;
			res_dist_q  <= hit ? rd_a_q[DIST_OUT_W-1:0] : '0;
			res_pred_q  <= hit ? rd_p_q : '0;
		end
	end

	assign reachable   = res_reach_q;
	assign distance    = res_dist_q;
	assign predecessor = res_pred_q;

	// Status toward the controller.
	always_comb begin
		sts.kind      = kind_q;
		sts.in_range  = in_range;
		sts.n_zero    = (n_ext == '0);
		sts.ab_inf    = (rd_a_q == DIST_INF);
		sts.ba_inf    = (rd_b_q == DIST_INF);
		sts.self_loop = (a_q == b_q);
		sts.ik_inf    = (rd_a_q == DIST_INF);
		sts.clr_last  = &clr_q;
		sts.j_last    = (CMPW'(j_q) == n_last);
		sts.i_last    = (CMPW'(i_q) == n_last);
		sts.k_last    = (CMPW'(k_q) == n_last);
	end

endmodule

`default_nettype wire

>>> rtl/all_pairs_shortest_paths_core.sv
// Top level of the all-pairs shortest-path core: controller and datapath joined by command/status.
`default_nettype none

// Floyd-Warshall core over an undirected graph of up to MAX_VERTICES vertices. One word in gives
// one word out; an edge load with an endpoint out of range writes nothing. A solve skips the pass
// over j for every pair (i,k) with no path from i to k. The relaxation step reads d(k,j) and d(i,j)
// and then writes d(i,j) through the single write port of the distance memory. After reset, while
// the core sweeps the distance memory to the unreachable code, no word is accepted; the vertex
// count register can be written at any time it is idle. A new word can be accepted while the
// previous result still waits on the output.
module all_pairs_shortest_paths_core import apsp_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [VC_W-1:0] cfg_wdata,
	apsp_item_if.sink            items,
	apsp_result_if.source        results
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// Sequencer.
	apsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Tables, counters and arithmetic.
	apsp_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.kind          (items.kind),
		.first_vertex  (items.first_vertex),
		.second_vertex (items.second_vertex),
		.weight        (items.weight),
		.cmd           (cmd),
		.sts           (sts),
		.reachable     (results.reachable),
		.distance      (results.distance),
		.predecessor   (results.predecessor)
	);

endmodule

`default_nettype wire

>>> rtl/apsp_checker.sv
// Port-level checker of the shortest-path core and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module apsp_checker import apsp_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  items_valid,
	input wire logic                  items_ready,
	input wire logic                  results_valid,
	input wire logic                  results_ready,
	input wire logic                  results_reachable,
	input wire logic [DIST_OUT_W-1:0] results_distance,
	input wire logic [PRED_W-1:0]     results_predecessor
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = items_valid && items_ready;
	assign out_acc = results_valid && results_ready;

	// Words accepted whose result word has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	`AP_ASSERT_RST(a_valid_hold, clk, arst_n, results_valid && !results_ready |=> results_valid, "result valid dropped while stalled")
	`AP_ASSERT_RST(a_payload_hold, clk, arst_n, results_valid && !results_ready |=> $stable(results_reachable) && $stable(results_distance) && $stable(results_predecessor), "result word changed while stalled")
	`AP_ASSERT_ALWAYS(a_unreach_zero, clk, results_valid && !results_reachable |-> results_distance == '0 && results_predecessor == '0, "unreachable result carries nonzero fields")
	`AP_ASSERT_RST(a_ready_balance, clk, arst_n, items_ready |-> pend_q == {1'b0, results_valid}, "input ready with a result neither shown nor delivered")
	`AP_ASSERT_RST(a_no_orphan, clk, arst_n, results_valid |-> pend_q != 2'd0, "result word without an accepted input word")

endmodule

bind all_pairs_shortest_paths_core apsp_checker u_apsp_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.items_valid         (items.valid),
	.items_ready         (items.ready),
	.results_valid       (results.valid),
	.results_ready       (results.ready),
	.results_reachable   (results.reachable),
	.results_distance    (results.distance),
	.results_predecessor (results.predecessor)
);

`default_nettype wire

>>> tb/tb_all_pairs_shortest_paths_core.sv
// Self-checking testbench of the all-pairs shortest-path core under random valid/ready traffic.
module tb_all_pairs_shortest_paths_core import apsp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXV         = MAX_VERTICES_DEF;
	localparam int CELL_COUNT   = MAXV * MAXV;
	localparam int IDLE_PCT     = 28;
	localparam int RANDOM_WORDS = 500;
	localparam int LIMIT_CYCLES = 4_000_000;

	typedef struct packed {
		kind_t               kind;
		logic [VTX_W-1:0]    first_vertex;
		logic [VTX_W-1:0]    second_vertex;
		logic [WEIGHT_W-1:0] weight;
	} graph_word_t;

	typedef struct packed {
		logic                  reachable;
		logic [DIST_OUT_W-1:0] distance;
		logic [PRED_W-1:0]     predecessor;
	} path_answer_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_we;
	logic [VC_W-1:0] cfg_wdata;

	apsp_item_if   items ();
	apsp_result_if results ();

	all_pairs_shortest_paths_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.results   (results)
	);

	// Shadow copy of the graph tables and the vertex count register.
	logic [DIST_W-1:0] dist_tbl [CELL_COUNT];
	logic [PRED_W-1:0] pred_tbl [CELL_COUNT];
	logic [VC_W-1:0]   vc_model;

	graph_word_t  pending_words[$];
	path_answer_t expected_answers[$];
	graph_word_t  word_on_bus;

	int words_queued;
	int words_accepted;
	int answers_checked;
	int reach_answers;
	int solves_seen;
	int clears_seen;
	int error_count;
	int cycle_count;
	bit no_gaps;

	always #5ns clk = ~clk;

	// Writes one direction of an edge unless that pair already holds a distance.
	function automatic void store_edge(int src, int dst, logic [DIST_W-1:0] w);
		int idx;
		idx = src * MAXV + dst;
		if (dist_tbl[idx] == DIST_INF) begin
			dist_tbl[idx] = w;
			pred_tbl[idx] = PRED_W'(src);
		end
	endfunction

	// Applies one accepted word to the shadow tables and returns the answer it must produce.
	function automatic path_answer_t apply_word(graph_word_t w);
		path_answer_t      ans;
		int                n, k, i, j, idx;
		logic [DIST_W-1:0] d_ik, d_kj;
		logic [DIST_W:0]   sum;
		ans = '0;
		n = (vc_model < MAXV) ? int'(vc_model) : MAXV;
		case (w.kind)
			KIND_CLEAR: begin
				for (idx = 0; idx < CELL_COUNT; idx++)
					dist_tbl[idx] = DIST_INF;
			end
			KIND_EDGE: begin
				if (w.first_vertex < n && w.second_vertex < n) begin
					store_edge(w.first_vertex, w.second_vertex, DIST_W'(w.weight));
					store_edge(w.second_vertex, w.first_vertex, DIST_W'(w.weight));
				end
			end
			KIND_SOLVE: begin
				// In-place k-i-j relaxation; sums saturate at the largest finite distance.
				for (k = 0; k < n; k++) begin
					for (i = 0; i < n; i++) begin
						d_ik = dist_tbl[i * MAXV + k];
						if (d_ik != DIST_INF) begin
							for (j = 0; j < n; j++) begin
								d_kj = dist_tbl[k * MAXV + j];
								if (d_kj != DIST_INF) begin
									sum = d_ik + d_kj;
									if (sum > DIST_MAX)
										sum = DIST_MAX;
									if (sum < {1'b0, dist_tbl[i * MAXV + j]}) begin
										dist_tbl[i * MAXV + j] = sum[DIST_W-1:0];
										pred_tbl[i * MAXV + j] = pred_tbl[k * MAXV + j];
									end
								end
							end
						end
					end
				end
			end
			default: begin
				if (w.first_vertex < n && w.second_vertex < n) begin
					idx = w.first_vertex * MAXV + w.second_vertex;
					if (dist_tbl[idx] != DIST_INF) begin
						ans.reachable   = 1'b1;
						ans.distance    = dist_tbl[idx][DIST_OUT_W-1:0];
						ans.predecessor = pred_tbl[idx];
					end
				end
			end
		endcase
		return ans;
	endfunction

	task automatic queue_word(kind_t kind, int a, int b, int w);
		graph_word_t gw;
		gw.kind          = kind;
		gw.first_vertex  = VTX_W'(a);
		gw.second_vertex = VTX_W'(b);
		gw.weight        = WEIGHT_W'(w);
		pending_words.push_back(gw);
		words_queued++;
	endtask

	// Holds until every queued word is accepted and every answer has come back.
	task automatic wait_drained();
		while (words_accepted != words_queued || expected_answers.size() != 0)
			@(negedge clk);
	endtask

	// The register is only written while the core is idle.
	task automatic write_vertex_count(int v);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= VC_W'(v);
		@(posedge clk);
		cfg_we    <= 1'b0;
		vc_model  = VC_W'(v);
	endtask

	// Mostly a vertex in use, sometimes any vertex the field can hold.
	function automatic int pick_vertex(int n);
		if (n > 0 && $urandom_range(9) != 0)
			return $urandom_range(n - 1);
		return $urandom_range(63);
	endfunction

	function automatic int pick_weight();
		int r;
		r = $urandom_range(7);
		if (r == 0)
			return 0;
		if (r == 1)
			return 65535;
		if (r < 5)
			return $urandom_range(255);
		return $urandom_range(65535);
	endfunction

	// Driver: holds a word until it is taken, then presents the next pending one.
	always @(posedge clk) begin
		graph_word_t nxt;
		bit          gap;
		if (!arst_n) begin
			items.valid <= 1'b0;
		end else begin
			if (items.valid && items.ready) begin
				expected_answers.push_back(apply_word(word_on_bus));
				words_accepted++;
				if (word_on_bus.kind == KIND_SOLVE)
					solves_seen++;
				if (word_on_bus.kind == KIND_CLEAR)
					clears_seen++;
			end
			if (!items.valid || items.ready) begin
				gap = !no_gaps && ($urandom_range(99) < IDLE_PCT);
				if (pending_words.size() != 0 && !gap) begin
					nxt = pending_words.pop_front();
					word_on_bus         = nxt;
					items.valid         <= 1'b1;
					items.kind          <= nxt.kind;
					items.first_vertex  <= nxt.first_vertex;
					items.second_vertex <= nxt.second_vertex;
					items.weight        <= nxt.weight;
				end else begin
					items.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each accepted result word with the oldest expected answer.
	always @(posedge clk) begin
		path_answer_t want;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (expected_answers.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result word, expected none, actual %0b/%0d/%0d",
						$time, results.reachable, results.distance, results.predecessor);
				end else begin
					want = expected_answers.pop_front();
					answers_checked++;
					if (want.reachable)
						reach_answers++;
					if (results.reachable !== want.reachable) begin
						error_count++;
						$display("%0t: reachable expected %0b, actual %0b",
							$time, want.reachable, results.reachable);
					end
					if (results.distance !== want.distance) begin
						error_count++;
						$display("%0t: distance expected %0d, actual %0d",
							$time, want.distance, results.distance);
					end
					if (results.predecessor !== want.predecessor) begin
						error_count++;
						$display("%0t: predecessor expected %0d, actual %0d",
							$time, want.predecessor, results.predecessor);
					end
				end
			end
			results.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Run stopped after %0d cycles with %0d answers outstanding.",
				cycle_count, expected_answers.size());
			$display("tb_all_pairs_shortest_paths_core failed");
			$finish;
		end
	end

	initial begin
		int n, ep, cnt, v, r, directed_words;
		bit wide_graph;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = VC_RESET;
		items.valid         = 1'b0;
		items.kind          = '0;
		items.first_vertex  = '0;
		items.second_vertex = '0;
		items.weight        = '0;
		results.ready       = 1'b0;
		vc_model            = VC_RESET;
		no_gaps             = 1'b0;
		for (int c = 0; c < CELL_COUNT; c++) begin
			dist_tbl[c] = DIST_INF;
			pred_tbl[c] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Nothing is reachable straight after reset.
		queue_word(KIND_QUERY, 0, 0, 0);

		// Small graph: weight limits, repeated pair, self loop, vertices out of range.
		write_vertex_count(4);
		queue_word(KIND_EDGE, 0, 1, 0);
		queue_word(KIND_EDGE, 1, 2, 65535);
		queue_word(KIND_EDGE, 0, 1, 5);
		queue_word(KIND_EDGE, 2, 2, 7);
		queue_word(KIND_EDGE, 3, 5, 1);
		queue_word(KIND_EDGE, 63, 63, 2);
		queue_word(KIND_QUERY, 1, 0, 0);
		queue_word(KIND_QUERY, 0, 5, 0);
		queue_word(KIND_SOLVE, 0, 0, 0);
		queue_word(KIND_QUERY, 0, 2, 0);
		queue_word(KIND_QUERY, 0, 0, 0);
		queue_word(KIND_QUERY, 2, 2, 0);
		// A pair found by the solve keeps its distance against a later edge.
		queue_word(KIND_EDGE, 0, 2, 3);
		queue_word(KIND_QUERY, 0, 2, 0);
		queue_word(KIND_QUERY, 3, 3, 0);
		queue_word(KIND_CLEAR, 0, 0, 0);
		queue_word(KIND_QUERY, 0, 1, 0);

		// No vertices in use: everything is out of range and the solve is empty.
		write_vertex_count(0);
		queue_word(KIND_EDGE, 0, 0, 9);
		queue_word(KIND_SOLVE, 0, 0, 0);
		queue_word(KIND_QUERY, 0, 0, 0);

		// A single vertex with a self loop.
		write_vertex_count(1);
		queue_word(KIND_EDGE, 0, 0, 9);
		queue_word(KIND_SOLVE, 0, 0, 0);
		queue_word(KIND_QUERY, 0, 0, 0);
		queue_word(KIND_QUERY, 0, 1, 0);

		// Counts above the table size are clipped to the full table.
		write_vertex_count(127);
		queue_word(KIND_CLEAR, 0, 0, 0);
		queue_word(KIND_EDGE, 63, 62, 40000);
		queue_word(KIND_EDGE, 62, 0, 30000);
		queue_word(KIND_SOLVE, 0, 0, 0);
		queue_word(KIND_QUERY, 63, 0, 0);
		queue_word(KIND_QUERY, 0, 63, 0);
		queue_word(KIND_QUERY, 62, 62, 0);
		write_vertex_count(64);
		queue_word(KIND_QUERY, 63, 0, 0);
		directed_words = words_queued;

		// Random episodes: a vertex count, edges, a solve and queries, then a little noise.
		ep = 0;
		while (words_queued - directed_words < RANDOM_WORDS) begin
			r = $urandom_range(19);
			if (r == 0)
				v = 0;
			else if (r == 1)
				v = 1;
			else if (r == 2)
				v = 64;
			else if (r == 3)
				v = 127;
			else
				v = $urandom_range(2, 12);
			// One long stretch runs with neither side idling.
			no_gaps = (ep >= 6 && ep < 9);
			write_vertex_count(v);
			n = (v < MAXV) ? v : MAXV;
			wide_graph = (n > 12);
			if (wide_graph || $urandom_range(2) == 0)
				queue_word(KIND_CLEAR, 0, 0, 0);
			cnt = wide_graph ? $urandom_range(3, 10) : $urandom_range(1, 2 * n + 1);
			repeat (cnt)
				queue_word(KIND_EDGE, pick_vertex(n), pick_vertex(n), pick_weight());
			repeat ($urandom_range(2))
				queue_word(KIND_QUERY, pick_vertex(n), pick_vertex(n), $urandom_range(65535));
			queue_word(KIND_SOLVE, $urandom_range(63), $urandom_range(63), $urandom_range(65535));
			repeat ($urandom_range(4, 12))
				queue_word(KIND_QUERY, pick_vertex(n), pick_vertex(n), $urandom_range(65535));
			if ($urandom_range(1) == 1) begin
				repeat ($urandom_range(1, 3))
					queue_word(KIND_EDGE, pick_vertex(n), pick_vertex(n), pick_weight());
				queue_word(KIND_SOLVE, 0, 0, 0);
				repeat (3)
					queue_word(KIND_QUERY, pick_vertex(n), pick_vertex(n), 0);
			end
			// Noise words with any kind and any field values, clears kept rare.
			if (!wide_graph) begin
				repeat ($urandom_range(4)) begin
					r = $urandom_range(15);
					queue_word(r == 0 ? KIND_CLEAR : (r < 6 ? KIND_EDGE :
						(r < 8 ? KIND_SOLVE : KIND_QUERY)),
						$urandom_range(63), $urandom_range(63), $urandom_range(65535));
				end
			end
			ep++;
		end

		wait_drained();
		repeat (16) @(posedge clk);
		$display("Checked %0d result words (%0d reachable) over %0d solves and %0d clears.",
			answers_checked, reach_answers, solves_seen, clears_seen);
		$display("Vertex counts ran from 0 to 127 across %0d random episodes.", ep);
		if (error_count == 0 && expected_answers.size() == 0) begin
			$display("tb_all_pairs_shortest_paths_core passed");
		end else begin
			$display("tb_all_pairs_shortest_paths_core failed");
		end
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl
rtl/apsp_pkg.sv
rtl/apsp_item_if.sv
rtl/apsp_result_if.sv
rtl/apsp_ctrl.sv
rtl/apsp_datapath.sv
rtl/all_pairs_shortest_paths_core.sv
rtl/apsp_checker.sv
tb/tb_all_pairs_shortest_paths_core.sv
